FILE: rtl/rbdq_pkg.sv
// ----------------------------------------------------------------------------
// rbdq_pkg
// Shared types and field widths for the ring buffer deque core and its
// storage cells.
// ----------------------------------------------------------------------------
package rbdq_pkg;

  // Fixed widths of the item fields on the ports.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ       = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // What every cell does at a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_PUSH_FRONT = 2'd1,  // take the word of the neighbor nearer the front
    CELL_POP_FRONT  = 2'd2,  // take the word of the neighbor nearer the back
    CELL_PUSH_BACK  = 2'd3   // the cell at the tail index loads the new word
  } cell_op_e;

endpackage

FILE: rtl/rbdq_cell.sv
// ----------------------------------------------------------------------------
// rbdq_cell
// One storage cell of the deque chain. Holds one word and shifts it to or
// from its neighbors, or loads a new word when it sits at the tail.
// ----------------------------------------------------------------------------
module rbdq_cell import rbdq_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [IDX_W-1:0]      tail_idx_i,
  input  logic [IDX_W-1:0]      sel_idx_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] prev_word_i,
  input  logic [DATA_WIDTH-1:0] next_word_i,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic [DATA_WIDTH-1:0] rd_word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    unique case (op_i)
      CELL_HOLD:       word_d = word_q;
      CELL_PUSH_FRONT: word_d = prev_word_i;
      CELL_POP_FRONT:  word_d = next_word_i;
      CELL_PUSH_BACK: begin
        if (tail_idx_i == MyIdx) begin
          word_d = value_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (sel_idx_i == MyIdx) ? word_q : '0;

endmodule

FILE: rtl/ring_buffer_deque_core.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_core
// Fixed-capacity double-ended queue of DEPTH words. Each input item is one
// command (push back, push front, pop back, pop front, read by position) and
// returns one result item: the removed or read word, a status and the new
// occupancy.
//
// Input channel: in_valid_i with command_i, value_i, position_i; the block
// drives in_stall_o. Output channel: out_valid_o with read_word_o, status_o,
// occupancy_o; the receiver drives out_stall_i.
// The words sit in a row of cells kept in order from the front. Front pushes
// and pops shift the whole row by one cell; back pushes load the cell at the
// occupancy index. Every command finishes in the cycle it is accepted, and
// its result is registered in the output register, so the block takes one
// item per cycle unless the output stalls; the cell updates set that rate.
// While a result waits under out_stall_i, in_stall_o is high and nothing
// moves. Reset empties the deque and clears the output valid; the cell
// contents stay undefined until written and are never read before then.
// ----------------------------------------------------------------------------
module ring_buffer_deque_core import rbdq_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CMD_W-1:0]           command_i,
  input  logic signed [WORD_W-1:0]   value_i,
  input  logic [POS_W-1:0]           position_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [WORD_W-1:0]   read_word_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [OCC_W-1:0]           occupancy_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic                  in_accept;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_m1;
  logic                  full, empty;
  cell_op_e              cell_op;
  logic [IDX_W-1:0]      sel_idx;
  logic                  word_en;
  status_e               status;
  logic [DATA_WIDTH-1:0] value_w;
  logic [DATA_WIDTH-1:0] rd_word;

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  logic                  out_valid_q, out_valid_d;
  logic [WORD_W-1:0]     read_word_q;
  logic [STATUS_W-1:0]   status_q;
  logic [OCC_W-1:0]      occupancy_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign full    = (cnt_q == CntFull);
  assign empty   = (cnt_q == '0);
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign value_w = DATA_WIDTH'($unsigned(value_i));

  always_comb begin
    cnt_d   = cnt_q;
    cell_op = CELL_HOLD;
    sel_idx = '0;
    word_en = 1'b0;
    status  = ST_OK;
    unique case (command_i)
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cell_op = CELL_PUSH_BACK;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cell_op = CELL_PUSH_FRONT;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          sel_idx = cnt_m1[IDX_W-1:0];
          word_en = 1'b1;
          cnt_d   = cnt_m1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cell_op = CELL_POP_FRONT;
          word_en = 1'b1;
          cnt_d   = cnt_m1;
        end
      end
      CMD_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (int'(position_i) >= int'(cnt_q)) begin
          status = ST_RANGE;
        end else begin
          sel_idx = IDX_W'(position_i);
          word_en = 1'b1;
        end
      end
      default: begin
        // Unknown commands leave the deque alone and report success.
        status = ST_OK;
      end
    endcase
    // The cells only move on an accepted item.
    if (!in_accept) begin
      cell_op = CELL_HOLD;
    end
  end

  // The row of cells. Cell 0 is the front; a front push feeds it the new
  // word, and the last cell refills with its own word on a front pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_word;
    logic [DATA_WIDTH-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = value_w;
    end else begin : g_mid
      assign prev_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_word[i];
    end else begin : g_inner
      assign next_word = cell_word[i+1];
    end

    rbdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .tail_idx_i  (cnt_q[IDX_W-1:0]),
      .sel_idx_i   (sel_idx),
      .value_i     (value_w),
      .prev_word_i (prev_word),
      .next_word_i (next_word),
      .word_o      (cell_word[i]),
      .rd_word_o   (cell_rd[i])
    );
  end

  // Only the selected cell drives a nonzero word, so an OR collects it.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign out_valid_d = in_accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      read_word_q <= word_en ? WORD_W'(rd_word) : '0;
      status_q    <= status;
      occupancy_q <= OCC_W'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_word_o = $signed(read_word_q);
  assign status_o    = status_q;
  assign occupancy_o = occupancy_q;

endmodule
